// ===== hdl/rcn_pkg.sv =====
package rcn_pkg;

   localparam int MAX_WIDTH_DEF = 2048;
   localparam int COEF_BITS_DEF = 8;
   localparam int PIX_W         = 24;
   localparam int CH_W          = 8;
   localparam int IMG_W_BITS    = 12;
   localparam int IMG_H_BITS    = 16;
   localparam int CSR_IDX_W     = 3;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 16'd480;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROW0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROW1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROW2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd4;

   typedef struct packed {
      logic             op;
      logic [PIX_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             last_of_frame;
   } rsp_type;

   typedef logic [8:0][PIX_W-1:0] window_type;

   // One emitted output as handed from the front end to the arithmetic back end.
   typedef struct packed {
      window_type win;
      logic       pass;
      logic       last;
   } entry_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_MAC,
      BACK_PREP,
      BACK_DIV,
      BACK_OUT
   } back_state_type;

endpackage

// ===== hdl/rcn_ram.sv =====
module rcn_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rcn_queue.sv =====
module rcn_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rcn_pkg::entry_type  push_data,
   input  logic                pop,
   output rcn_pkg::entry_type  pop_data,
   output logic                empty,
   output logic                full
);

   localparam int PW = (rcn_pkg::QUEUE_DEPTH > 1) ? $clog2(rcn_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(rcn_pkg::QUEUE_DEPTH + 1);

   rcn_pkg::entry_type slot_ff [rcn_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(rcn_pkg::QUEUE_DEPTH));
   assign pop_data = slot_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PW'(rcn_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PW'(rcn_pkg::QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/rcn_front.sv =====
module rcn_front #(
   parameter int MAX_WIDTH = rcn_pkg::MAX_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rcn_pkg::req_type                   req_word,
   input  logic [rcn_pkg::IMG_W_BITS-1:0]     image_width,
   input  logic [rcn_pkg::IMG_H_BITS-1:0]     image_height,
   input  logic                               q_full,
   output logic                               q_push,
   output rcn_pkg::entry_type                 q_entry
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int HW = rcn_pkg::IMG_H_BITS;

   rcn_pkg::front_state_type state_ff, state_in;

   logic [CW-1:0] col_ff, col_in;
   logic [HW-1:0] row_ff, row_in;
   logic [CW-1:0] fpos_ff, fpos_in;

   logic [rcn_pkg::PIX_W-1:0] px_ff;
   logic [AW-1:0]             idx_ff;
   logic                      emit_ff, pass_ff, last_ff;
   rcn_pkg::window_type       win_ff, win_in;

   logic [31:0]   w_raw;
   logic [CW-1:0] eff_w;
   logic [HW-1:0] eff_h;
   logic          flush_mode;
   logic [CW-1:0] c, k, pc;
   logic [HW-1:0] pr;
   logic [CW-1:0] rd_idx;
   logic          take, useful;
   logic          emit_now, pass_now, last_now;
   logic [rcn_pkg::PIX_W-1:0] upper_rd, middle_rd;

   assign w_raw = 32'(image_width);
   assign eff_w = (image_width == '0) ? CW'(1) :
                  (w_raw > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(w_raw);
   assign eff_h = (image_height == '0) ? HW'(1) : image_height;

   assign flush_mode = (row_ff >= eff_h);
   assign c  = (col_ff >= eff_w) ? eff_w - 1'b1 : col_ff;
   assign k  = (fpos_ff > eff_w) ? eff_w : fpos_ff;
   assign rd_idx = flush_mode ? ((k < eff_w) ? k : '0) : c;

   assign req_stall = (state_ff != rcn_pkg::FRONT_IDLE) || q_full;
   assign take      = req_valid && !req_stall;
   assign useful    = take && (flush_mode ? (req_word.op == rcn_pkg::OP_FLUSH)
                                          : (req_word.op == rcn_pkg::OP_PIXEL));

   // Position of the output pixel relative to the newest input.
   always_comb begin
      if (c >= CW'(1)) begin
         pr = row_ff - 1'b1;
         pc = c - 1'b1;
      end else begin
         pr = (row_ff >= HW'(2)) ? row_ff - HW'(2) : '0;
         pc = eff_w - 1'b1;
      end
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      fpos_in  = fpos_ff;
      emit_now = 1'b0;
      pass_now = 1'b1;
      last_now = 1'b0;
      if (flush_mode) begin
         emit_now = (k >= CW'(1)) || (eff_h >= HW'(2));
         last_now = (k >= eff_w);
         if (k >= eff_w) begin
            col_in  = '0;
            row_in  = '0;
            fpos_in = '0;
         end else begin
            fpos_in = k + 1'b1;
         end
      end else begin
         emit_now = (row_ff >= HW'(2)) || ((row_ff == HW'(1)) && (c >= CW'(1)));
         pass_now = (pr == '0) || ({1'b0, pr} + 1'b1 >= {1'b0, eff_h}) ||
                    (pc == '0) || ({1'b0, pc} + 1'b1 >= {1'b0, eff_w});
         if ({1'b0, c} + 1'b1 >= {1'b0, eff_w}) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = c + 1'b1;
         end
      end
   end

   rcn_ram #(.WIDTH(rcn_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (state_ff == rcn_pkg::FRONT_PUSH),
      .wr_addr (idx_ff),
      .wr_data (middle_rd),
      .rd_en   (useful),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (upper_rd)
   );

   rcn_ram #(.WIDTH(rcn_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (state_ff == rcn_pkg::FRONT_PUSH),
      .wr_addr (idx_ff),
      .wr_data (px_ff),
      .rd_en   (useful),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (middle_rd)
   );

   always_comb begin
      win_in = win_ff;
      for (int r = 0; r < 3; r++) begin
         win_in[3*r]     = win_ff[3*r + 1];
         win_in[3*r + 1] = win_ff[3*r + 2];
      end
      win_in[2] = upper_rd;
      win_in[5] = middle_rd;
      win_in[8] = px_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rcn_pkg::FRONT_IDLE: begin
            if (useful) begin
               state_in = rcn_pkg::FRONT_PUSH;
            end
         end
         rcn_pkg::FRONT_PUSH: begin
            state_in = rcn_pkg::FRONT_IDLE;
         end
         default: state_in = rcn_pkg::FRONT_IDLE;
      endcase
   end

   assign q_push       = (state_ff == rcn_pkg::FRONT_PUSH) && emit_ff;
   assign q_entry.win  = win_in;
   assign q_entry.pass = pass_ff;
   assign q_entry.last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcn_pkg::FRONT_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         fpos_ff  <= '0;
         win_ff   <= '0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (useful) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            fpos_ff <= fpos_in;
            emit_ff <= emit_now;
         end
         if (state_ff == rcn_pkg::FRONT_PUSH) begin
            win_ff <= win_in;
         end
      end
      if (useful) begin
         px_ff   <= flush_mode ? '0 : req_word.pixel_in;
         idx_ff  <= rd_idx[AW-1:0];
         pass_ff <= pass_now;
         last_ff <= last_now;
      end
   end

endmodule

// ===== hdl/rcn_back.sv =====
module rcn_back #(
   parameter int COEF_BITS = rcn_pkg::COEF_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [2:0][3*COEF_BITS-1:0]        kernel,
   input  logic                               q_empty,
   input  rcn_pkg::entry_type                 q_entry,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rcn_pkg::rsp_type                   rsp_word
);

   localparam int ACC_W = COEF_BITS + 13;
   localparam int KS_W  = COEF_BITS + 4;
   localparam int DC_W  = $clog2(ACC_W + 1);
   localparam int PR_W  = COEF_BITS + 9;

   rcn_pkg::back_state_type state_ff, state_in;

   rcn_pkg::window_type       win_ff;
   logic [3:0]                tap_ff;
   logic [1:0]                rsel_ff, csel_ff;
   logic signed [ACC_W-1:0]   acc_ff [3];
   logic signed [KS_W-1:0]    ksum_ff;
   logic [ACC_W-1:0]          quot_ff [3];
   logic [KS_W:0]             rem_ff [3];
   logic [2:0]                neg_ff;
   logic [KS_W-1:0]           dvs_ff;
   logic [DC_W-1:0]           dcnt_ff;
   logic                      rsp_valid_ff;
   rcn_pkg::rsp_type          rsp_word_ff;

   logic                      out_free;
   logic signed [COEF_BITS-1:0] cf;
   logic [rcn_pkg::PIX_W-1:0] tap_px;
   logic signed [PR_W-1:0]    prod [3];
   logic signed [KS_W-1:0]    ksum_eff;
   logic [KS_W:0]             rem_sh [3];
   logic [rcn_pkg::PIX_W-1:0] filt;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cf       = kernel[csel_ff][rsel_ff*COEF_BITS +: COEF_BITS];
   assign tap_px   = win_ff[tap_ff];
   assign ksum_eff = (ksum_ff == '0) ? KS_W'(1) : ksum_ff;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch]   = $signed({1'b0, tap_px[8*ch +: 8]}) * cf;
         rem_sh[ch] = {rem_ff[ch][KS_W-1:0], quot_ff[ch][ACC_W-1]};
      end
   end

   // Clamp the truncated quotients into 0..255.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         if (neg_ff[ch]) begin
            filt[8*ch +: 8] = '0;
         end else if (quot_ff[ch] > ACC_W'(255)) begin
            filt[8*ch +: 8] = 8'hff;
         end else begin
            filt[8*ch +: 8] = quot_ff[ch][7:0];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         rcn_pkg::BACK_IDLE: begin
            if (!q_empty) begin
               if (!q_entry.pass) begin
                  q_pop    = 1'b1;
                  state_in = rcn_pkg::BACK_MAC;
               end else if (out_free) begin
                  q_pop = 1'b1;
               end
            end
         end
         rcn_pkg::BACK_MAC: begin
            if (tap_ff == 4'd8) begin
               state_in = rcn_pkg::BACK_PREP;
            end
         end
         rcn_pkg::BACK_PREP: state_in = rcn_pkg::BACK_DIV;
         rcn_pkg::BACK_DIV: begin
            if (dcnt_ff == DC_W'(1)) begin
               state_in = rcn_pkg::BACK_OUT;
            end
         end
         rcn_pkg::BACK_OUT: begin
            if (out_free) begin
               state_in = rcn_pkg::BACK_IDLE;
            end
         end
         default: state_in = rcn_pkg::BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcn_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == rcn_pkg::BACK_IDLE && q_pop && q_entry.pass) begin
            rsp_valid_ff <= 1'b1;
         end else if (state_ff == rcn_pkg::BACK_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      unique case (state_ff)
         rcn_pkg::BACK_IDLE: begin
            if (q_pop && q_entry.pass) begin
               rsp_word_ff.pixel_out     <= q_entry.win[4];
               rsp_word_ff.last_of_frame <= q_entry.last;
            end
            win_ff  <= q_entry.win;
            tap_ff  <= '0;
            rsel_ff <= '0;
            csel_ff <= '0;
            ksum_ff <= '0;
            for (int ch = 0; ch < 3; ch++) begin
               acc_ff[ch] <= '0;
            end
         end
         rcn_pkg::BACK_MAC: begin
            for (int ch = 0; ch < 3; ch++) begin
               acc_ff[ch] <= acc_ff[ch] + ACC_W'(prod[ch]);
            end
            ksum_ff <= ksum_ff + KS_W'(cf);
            tap_ff  <= tap_ff + 1'b1;
            if (csel_ff == 2'd2) begin
               csel_ff <= '0;
               rsel_ff <= rsel_ff + 1'b1;
            end else begin
               csel_ff <= csel_ff + 1'b1;
            end
         end
         rcn_pkg::BACK_PREP: begin
            dvs_ff  <= ksum_eff[KS_W-1] ? KS_W'(-ksum_eff) : ksum_eff;
            dcnt_ff <= DC_W'(ACC_W);
            for (int ch = 0; ch < 3; ch++) begin
               quot_ff[ch] <= acc_ff[ch][ACC_W-1] ? ACC_W'(-acc_ff[ch]) : acc_ff[ch];
               rem_ff[ch]  <= '0;
               neg_ff[ch]  <= acc_ff[ch][ACC_W-1] ^ ksum_eff[KS_W-1];
            end
         end
         rcn_pkg::BACK_DIV: begin
            dcnt_ff <= dcnt_ff - 1'b1;
            for (int ch = 0; ch < 3; ch++) begin
               if (rem_sh[ch] >= {1'b0, dvs_ff}) begin
                  rem_ff[ch]  <= rem_sh[ch] - {1'b0, dvs_ff};
                  quot_ff[ch] <= {quot_ff[ch][ACC_W-2:0], 1'b1};
               end else begin
                  rem_ff[ch]  <= rem_sh[ch];
                  quot_ff[ch] <= {quot_ff[ch][ACC_W-2:0], 1'b0};
               end
            end
         end
         rcn_pkg::BACK_OUT: begin
            if (out_free) begin
               rsp_word_ff.pixel_out     <= filt;
               rsp_word_ff.last_of_frame <= 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== hdl/rgb_convolution_3x3_normalized.sv =====
// Path: a border or flush word goes through the front end's read and push states and the queue
// into the output register; an interior pixel also passes the tap, prepare and divide states.
// The front end takes no new word until it has written the last (line store read, then write);
// interior pixels are limited by the shared multiply-accumulate and the bit-serial divider.
// Reset is synchronous and active high; it clears control state, loads the identity
// kernel and a 640x480 frame. The line stores are not cleared and need no clearing pass.
module rgb_convolution_3x3_normalized #(
   parameter int MAX_WIDTH = rcn_pkg::MAX_WIDTH_DEF,
   parameter int COEF_BITS = rcn_pkg::COEF_BITS_DEF,
   localparam int KERN_W   = 3 * COEF_BITS,
   localparam int CSR_W    = (KERN_W > rcn_pkg::IMG_H_BITS) ? KERN_W : rcn_pkg::IMG_H_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rcn_pkg::req_type                req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rcn_pkg::rsp_type                rsp_word,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rcn_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]                csr_wdata
);

   // Configuration registers. Writes must land only while the block is idle; the user must keep
   // to this, as the block itself does not enforce it, and takes them every cycle without any interlock.
   logic [2:0][KERN_W-1:0]             kernel_ff;
   logic [rcn_pkg::IMG_W_BITS-1:0]     width_ff;
   logic [rcn_pkg::IMG_H_BITS-1:0]     height_ff;

   // Front end to back end queue signals.
   logic                q_push, q_pop, q_empty, q_full;
   rcn_pkg::entry_type  q_in, q_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff[0] <= '0;
         kernel_ff[1] <= KERN_W'(1) << COEF_BITS;
         kernel_ff[2] <= '0;
         width_ff     <= rcn_pkg::WIDTH_RESET;
         height_ff    <= rcn_pkg::HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            rcn_pkg::CSR_KERNEL_ROW0:  kernel_ff[0] <= csr_wdata[KERN_W-1:0];
            rcn_pkg::CSR_KERNEL_ROW1:  kernel_ff[1] <= csr_wdata[KERN_W-1:0];
            rcn_pkg::CSR_KERNEL_ROW2:  kernel_ff[2] <= csr_wdata[KERN_W-1:0];
            rcn_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[rcn_pkg::IMG_W_BITS-1:0];
            rcn_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[rcn_pkg::IMG_H_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // The front end tracks raster position, owns the two line stores and the 3x3
   // window, and decides for each word whether an output is due and whether it is
   // a border pixel that passes through.
   rcn_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .image_width  (width_ff),
      .image_height (height_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (q_in)
   );

   // A two-entry queue holds finished windows so the front end keeps going while the
   // back end divides.
   rcn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty),
      .full      (q_full)
   );

   // The back end runs one tap per cycle through three channel multipliers, then a
   // restoring divider by the kernel sum, then clamps into the output register.
   rcn_back #(.COEF_BITS(COEF_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .kernel    (kernel_ff),
      .q_empty   (q_empty),
      .q_entry   (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== hdl/rcn_checker.sv =====
module rcn_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input rcn_pkg::req_type                req_word,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input rcn_pkg::rsp_type                rsp_word
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_word))
      else $error("input word changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_word))
      else $error("result word changed while stalled");

   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   a_reset_open: assert property (@(posedge clock) $past(reset) |-> !req_stall)
      else $error("input stalled right after reset");

endmodule

bind rgb_convolution_3x3_normalized rcn_checker u_checker (.*);

// ===== tb/tb_rgb_convolution_3x3_normalized.sv =====
module tb_rgb_convolution_3x3_normalized;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W       = rcn_pkg::MAX_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 4000000;
   // The drain wait covers the slowest word, an interior pixel, in the back end.
   localparam int DRAIN_CYCLES = 60;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   rcn_pkg::req_type              req_word = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   rcn_pkg::rsp_type              rsp_word;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [rcn_pkg::CSR_IDX_W-1:0] csr_index = rcn_pkg::CSR_KERNEL_ROW0;
   logic [23:0]                   csr_wdata = '0;

   rgb_convolution_3x3_normalized DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow copy of the filter: configuration, line stores, window and positions.
   bit [23:0] kernel_rows [3] = '{24'd0, 24'd256, 24'd0};
   int        width_reg  = 640;
   int        height_reg = 480;
   bit [23:0] upper_line [MAX_W];
   bit [23:0] middle_line [MAX_W];
   bit [23:0] window_px [9];
   int        col_pos, row_pos, flush_pos;

   rcn_pkg::rsp_type expected_pixels [$];
   int        error_count = 0;
   int        cycle_count = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;

   function automatic int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
   endfunction

   function automatic int active_height();
      return (height_reg == 0) ? 1 : height_reg;
   endfunction

   function automatic int coefficient(int k);
      logic [7:0] b;
      int         c;
      b = 8'(kernel_rows[k / 3] >> ((k % 3) * 8));
      c = $signed(b);
      return c;
   endfunction

   // Shift the window one column left and bring in a new column from the line stores.
   function automatic void shift_column(int col, bit [23:0] px);
      int        idx;
      bit [23:0] u, m;
      idx = (col < MAX_W) ? col : 0;
      u = upper_line[idx];
      m = middle_line[idx];
      upper_line[idx]  = m;
      middle_line[idx] = px;
      for (int r = 0; r < 3; r++) begin
         window_px[3*r]   = window_px[3*r+1];
         window_px[3*r+1] = window_px[3*r+2];
      end
      window_px[2] = u;
      window_px[5] = m;
      window_px[8] = px;
   endfunction

   // Kernel is applied transposed; the sum is normalized and clamped per channel.
   function automatic bit [23:0] convolve_window();
      int        ksum, v;
      int        acc [3];
      bit [23:0] res;
      ksum = 0;
      res = '0;
      acc = '{0, 0, 0};
      for (int k = 0; k < 9; k++) ksum += coefficient(k);
      if (ksum == 0) ksum = 1;
      for (int k = 0; k < 9; k++)
         for (int ch = 0; ch < 3; ch++)
            acc[ch] += int'(window_px[k][8*ch +: 8]) * coefficient((k % 3) * 3 + k / 3);
      for (int ch = 0; ch < 3; ch++) begin
         v = acc[ch] / ksum;
         if (v > 255) v = 255;
         else if (v < 0) v = 0;
         res[8*ch +: 8] = v[7:0];
      end
      return res;
   endfunction

   // Advances the shadow state by one accepted word; returns 1 if it yields an output pixel.
   function automatic bit predict_output(rcn_pkg::req_type rq, output rcn_pkg::rsp_type rs);
      int w, h, k, c, r, pr, pc;
      bit emit;
      w = active_width();
      h = active_height();
      rs = '0;
      if (row_pos >= h) begin
         if (rq.op == rcn_pkg::OP_PIXEL) return 0;
         k = (flush_pos > w) ? w : flush_pos;
         shift_column((k < w) ? k : 0, 24'd0);
         emit = (k >= 1) || (h >= 2);
         if (k >= w) begin
            row_pos = 0;
            col_pos = 0;
            flush_pos = 0;
         end else begin
            flush_pos = k + 1;
         end
         rs.pixel_out = window_px[4];
         rs.last_of_frame = (k >= w);
         return emit;
      end
      if (rq.op == rcn_pkg::OP_FLUSH) return 0;
      r = row_pos;
      c = (col_pos >= w) ? w - 1 : col_pos;
      shift_column(c, rq.pixel_in);
      emit = (r >= 2) || (r == 1 && c >= 1);
      if (c >= 1) begin
         pr = r - 1;
         pc = c - 1;
      end else begin
         pr = (r >= 2) ? r - 2 : 0;
         pc = w - 1;
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = r + 1;
      end else begin
         col_pos = c + 1;
      end
      if (pr == 0 || pr + 1 >= h || pc == 0 || pc + 1 >= w)
         rs.pixel_out = window_px[4];
      else
         rs.pixel_out = convolve_window();
      rs.last_of_frame = 1'b0;
      return emit;
   endfunction

   // Sends one word, with random idle cycles first, and records its expected output.
   task automatic send_word(logic op, logic [23:0] px);
      rcn_pkg::req_type rq;
      rcn_pkg::rsp_type rs;
      rq.op = op;
      rq.pixel_in = px;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= rq;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (predict_output(rq, rs)) expected_pixels.push_back(rs);
   endtask

   // Waits for every expected pixel, then lets any output-less word finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [rcn_pkg::CSR_IDX_W-1:0] idx, logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         rcn_pkg::CSR_KERNEL_ROW0, rcn_pkg::CSR_KERNEL_ROW1, rcn_pkg::CSR_KERNEL_ROW2: begin
            kernel_rows[idx] = data;
         end
         rcn_pkg::CSR_IMAGE_WIDTH: begin
            width_reg = int'(data[11:0]);
         end
         rcn_pkg::CSR_IMAGE_HEIGHT: begin
            height_reg = int'(data[15:0]);
         end
         default: begin
         end
      endcase
   endtask

   task automatic set_kernel(logic [23:0] r0, logic [23:0] r1, logic [23:0] r2);
      write_reg(rcn_pkg::CSR_KERNEL_ROW0, r0);
      write_reg(rcn_pkg::CSR_KERNEL_ROW1, r1);
      write_reg(rcn_pkg::CSR_KERNEL_ROW2, r2);
   endtask

   task automatic set_size(int w, int h);
      write_reg(rcn_pkg::CSR_IMAGE_WIDTH, 24'(w));
      write_reg(rcn_pkg::CSR_IMAGE_HEIGHT, 24'(h));
   endtask

   function automatic logic [23:0] random_pixel();
      case ($urandom_range(7))
         0: return 24'h000000;
         1: return 24'hffffff;
         default: return 24'($urandom_range(24'hffffff));
      endcase
   endfunction

   // One whole frame: all pixels, then the flush words, with stray words of the wrong kind
   // mixed in at the given rate. Returns the number of words that the block acts on.
   task automatic run_frame(int noise_pct, output int sent);
      int w, h;
      w = active_width();
      h = active_height();
      sent = 0;
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(99) < noise_pct) send_word(rcn_pkg::OP_FLUSH, random_pixel());
         send_word(rcn_pkg::OP_PIXEL, random_pixel());
         sent++;
      end
      for (int i = 0; i <= w; i++) begin
         if ($urandom_range(99) < noise_pct) send_word(rcn_pkg::OP_PIXEL, random_pixel());
         send_word(rcn_pkg::OP_FLUSH, random_pixel());
         sent++;
      end
   endtask

   // A 3x3 frame through the identity kernel that reset loads.
   task automatic test_reset_kernel();
      int n;
      set_size(3, 3);
      run_frame(0, n);
      wait_idle();
   endtask

   // Coefficient extremes: all +127, all -128 (negative normalizer), a mixed-sign kernel summing to -2.
   task automatic test_kernel_extremes();
      int n;
      set_size(3, 3);
      set_kernel(24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f);
      run_frame(0, n);
      wait_idle();
      set_kernel(24'h808080, 24'h808080, 24'h808080);
      run_frame(0, n);
      wait_idle();
      set_kernel(24'hff00ff, 24'h0201fe, 24'h0000ff);
      run_frame(10, n);
      wait_idle();
   endtask

   // Sizes at their limits: zero width and height, one column, one row.
   task automatic test_size_extremes();
      int n;
      set_kernel(24'h010201, 24'h020402, 24'h010201);
      set_size(0, 0);
      run_frame(20, n);
      wait_idle();
      set_size(1, 4);
      run_frame(20, n);
      wait_idle();
      set_size(5, 1);
      run_frame(20, n);
      wait_idle();
   endtask

   // A frame taller than what is sent, cut short by lowering the height while idle:
   // the rows already received become the whole frame and the flush phase follows.
   task automatic test_height_cut();
      set_size(2, 16'hffff);
      for (int i = 0; i < 6; i++) send_word(rcn_pkg::OP_PIXEL, random_pixel());
      wait_idle();
      write_reg(rcn_pkg::CSR_IMAGE_HEIGHT, 24'd3);
      for (int i = 0; i < 3; i++) send_word(rcn_pkg::OP_FLUSH, random_pixel());
      wait_idle();
   endtask

   // Random frames with random kernels, cycling through the idling phases.
   task automatic test_random_frames(int target);
      int total, n, phase;
      logic [23:0] rows [3];
      total = 0;
      phase = 0;
      while (total < target) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         for (int i = 0; i < 3; i++) begin
            if ($urandom_range(1))
               rows[i] = 24'($urandom_range(24'hffffff));
            else
               // Small coefficients, from -3 to 3, in every byte of the row.
               for (int j = 0; j < 3; j++) rows[i][8*j +: 8] = 8'($urandom_range(6) - 3);
         end
         set_kernel(rows[0], rows[1], rows[2]);
         if ($urandom_range(15) == 0)
            set_size($urandom_range(60, 3), $urandom_range(4, 2));
         else
            set_size($urandom_range(12, 1), $urandom_range(8, 1));
         run_frame($urandom_range(1) ? 0 : 5, n);
         total += n;
         wait_idle();
         phase++;
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Every accepted output word is matched against the oldest expected pixel.
   always @(posedge clock) begin
      rcn_pkg::rsp_type exp_rs;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected output %h", $time, rsp_word);
            error_count++;
         end else begin
            exp_rs = expected_pixels.pop_front();
            if (rsp_word.pixel_out !== exp_rs.pixel_out) begin
               $display("%0t: pixel_out expected %h actual %h", $time,
                        exp_rs.pixel_out, rsp_word.pixel_out);
               error_count++;
            end
            if (rsp_word.last_of_frame !== exp_rs.last_of_frame) begin
               $display("%0t: last_of_frame expected %b actual %b", $time,
                        exp_rs.last_of_frame, rsp_word.last_of_frame);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_kernel();
      test_kernel_extremes();
      test_size_extremes();
      test_height_cut();
      test_random_frames(1800);
      wait_idle();
      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (expected_pixels.size() != 0)
            $display("%0t: %0d expected pixels never arrived", $time, expected_pixels.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rcn_pkg.sv
hdl/rcn_ram.sv
hdl/rcn_queue.sv
hdl/rcn_front.sv
hdl/rcn_back.sv
hdl/rgb_convolution_3x3_normalized.sv
hdl/rcn_checker.sv
tb/tb_rgb_convolution_3x3_normalized.sv
